// ===== hw/rtl/clin_pkg.sv =====
`default_nettype none
package clin_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int CHIDX_W   = 3;
  localparam int ORDER_W   = 4;
  localparam int COUNT_W   = 4;
  localparam int LEAK_W    = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = LEAK_W;

  localparam logic [LEAK_W-1:0] LEAK_ONE = LEAK_W'(65536);

  localparam logic [ORDER_W-1:0] ORDER_RST = ORDER_W'(1);
  localparam logic [LEAK_W-1:0]  LEAK_RST  = LEAK_W'(64881);
  localparam logic [COUNT_W-1:0] COUNT_RST = COUNT_W'(2);

  // The leak is consumed least significant digit first: four 4-bit digits
  // for the fraction, then the single integer bit.
  localparam int DIGIT_W     = 4;
  localparam int FRAC_BITS   = 16;
  localparam int FRAC_DIGITS = FRAC_BITS / DIGIT_W;
  localparam int MUL_STEPS   = FRAC_DIGITS + 1;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORDER = 2'd0,
    CFG_LEAK  = 2'd1,
    CFG_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_MUL,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/clin_in_if.sv =====
`default_nettype none
interface clin_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [clin_pkg::SAMPLE_W-1:0] white_sample;

  modport source (output valid, output white_sample, input ready);
  modport sink (input valid, input white_sample, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/clin_out_if.sv =====
`default_nettype none
interface clin_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [clin_pkg::SAMPLE_W-1:0] noise_sample;
  logic [clin_pkg::CHIDX_W-1:0]         channel_index;

  modport source (output valid, output noise_sample, output channel_index, input ready);
  modport sink (input valid, input noise_sample, input channel_index, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/clin_stage_mem.sv =====
`default_nettype none
module clin_stage_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 24
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 wr_en,
  input  wire logic [AW-1:0]        wr_addr,
  input  wire logic signed [DW-1:0] wr_data,
  input  wire logic                 rd_en,
  input  wire logic [AW-1:0]        rd_addr,
  output logic signed [DW-1:0]      rd_data
);

  logic signed [DW-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     valid_r;
  logic signed [DW-1:0] rd_word_r;
  logic                 rd_valid_r;

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_word_r  <= mem[rd_addr];
      rd_valid_r <= valid_r[rd_addr];
    end
  end

  assign rd_data = rd_valid_r ? rd_word_r : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/clin_digit_mul.sv =====
`default_nettype none
module clin_digit_mul #(
  parameter int DW = 25
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic signed [DW-1:0]              diff,
  input  wire logic [clin_pkg::LEAK_W-1:0]       leak,
  output logic                                   done,
  output logic signed [DW-1:0]                   part
);

  localparam int ACC_W = DW + clin_pkg::DIGIT_W + 1;

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [clin_pkg::MUL_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [clin_pkg::LEAK_W-1:0]         leak_sh_r, leak_sh_nxt;
  logic signed [DW-1:0]                diff_r, diff_nxt;
  logic signed [ACC_W-1:0]             acc_r, acc_nxt;
  logic signed [clin_pkg::DIGIT_W:0]   digit;
  logic signed [ACC_W-1:0]             sum;

  // Each step adds diff times one digit and drops the digit's weight by an
  // arithmetic shift; the dropped bits are exactly what the floor discards.
  always_comb begin
    digit       = $signed({1'b0, leak_sh_r[clin_pkg::DIGIT_W-1:0]});
    sum         = acc_r + ACC_W'(diff_r * digit);
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    cnt_nxt     = cnt_r;
    leak_sh_nxt = leak_sh_r;
    diff_nxt    = diff_r;
    acc_nxt     = acc_r;
    if (start) begin
      busy_nxt    = 1'b1;
      cnt_nxt     = '0;
      leak_sh_nxt = leak;
      diff_nxt    = diff;
      acc_nxt     = '0;
    end else if (busy_r) begin
      if (int'(cnt_r) < clin_pkg::FRAC_DIGITS) begin
        acc_nxt     = sum >>> clin_pkg::DIGIT_W;
        leak_sh_nxt = leak_sh_r >> clin_pkg::DIGIT_W;
        cnt_nxt     = clin_pkg::MUL_CNT_W'(cnt_r + 1'b1);
      end else begin
        // The integer bit of the leak carries weight one after the shifts.
        acc_nxt  = leak_sh_r[0] ? acc_r + ACC_W'(diff_r) : acc_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r     <= cnt_nxt;
    leak_sh_r <= leak_sh_nxt;
    diff_r    <= diff_nxt;
    acc_r     <= acc_nxt;
  end

  assign done = done_r;
  assign part = DW'(acc_r);

endmodule
`default_nettype wire

// ===== hw/rtl/cascaded_leaky_integrator_noise.sv =====
`default_nettype none
// Cascaded one-pole lowpass for interleaved white noise. Each input beat is
// one Q1.15 sample of the next channel in turn; each output beat carries the
// top stage of that channel's cascade (Q1.15, truncated) and the channel
// number. Stage values live in a MAX_CHANNELS x MAX_ORDER word memory with a
// per-word valid flag, so reset clears them at once and no clearing pass is
// needed. Every stage runs through a memory read, a difference, the 4-bit
// digit-serial leak multiplier and the write-back. A new sample is taken
// only once the last one has reached the output register, and the input
// is taken again while that result still waits there.
module cascaded_leaky_integrator_noise #(
  parameter int MAX_ORDER    = 8,
  parameter int MAX_CHANNELS = 8,
  parameter int STATE_WIDTH  = 24
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  clin_in_if.sink                                in_if,
  clin_out_if.source                             out_if,
  input  wire logic                              cfg_we,
  input  wire logic [clin_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [clin_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int DEPTH   = MAX_CHANNELS * MAX_ORDER;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CH_W    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int ORD_W   = $clog2(MAX_ORDER + 1);
  localparam int CNT_W   = $clog2(MAX_CHANNELS + 1);
  localparam int SHIFT   = STATE_WIDTH - clin_pkg::SAMPLE_W;
  localparam int DW      = STATE_WIDTH + 1;

  // Configuration registers.
  logic [clin_pkg::ORDER_W-1:0] order_r;
  logic [clin_pkg::LEAK_W-1:0]  leak_r;
  logic [clin_pkg::COUNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= clin_pkg::ORDER_RST;
      leak_r  <= clin_pkg::LEAK_RST;
      count_r <= clin_pkg::COUNT_RST;
    end else if (cfg_we) begin
      unique case (clin_pkg::cfg_reg_t'(cfg_idx))
        clin_pkg::CFG_ORDER: order_r <= cfg_wdata[clin_pkg::ORDER_W-1:0];
        clin_pkg::CFG_LEAK:  leak_r  <= cfg_wdata[clin_pkg::LEAK_W-1:0];
        clin_pkg::CFG_COUNT: count_r <= cfg_wdata[clin_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [ORD_W-1:0]             order_sat;
  logic [clin_pkg::LEAK_W-1:0]  leak_sat;
  logic [CNT_W-1:0]             count_sat;

  always_comb begin
    order_sat = (int'(order_r) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : ORD_W'(order_r);
    leak_sat  = (leak_r > clin_pkg::LEAK_ONE) ? clin_pkg::LEAK_ONE : leak_r;
    if (count_r == '0) begin
      count_sat = CNT_W'(1);
    end else if (int'(count_r) > MAX_CHANNELS) begin
      count_sat = CNT_W'(MAX_CHANNELS);
    end else begin
      count_sat = CNT_W'(count_r);
    end
  end

  // Sequencer and datapath registers.
  clin_pkg::state_t             state_r, state_nxt;
  logic [CH_W-1:0]              cur_r;
  logic [CH_W-1:0]              ch_r;
  logic [ORD_W-1:0]             stage_cnt_r;
  logic [AW-1:0]                addr_r;
  logic signed [STATE_WIDTH-1:0] prev_r;
  logic                         out_valid_r;
  logic signed [clin_pkg::SAMPLE_W-1:0] out_noise_r;
  logic [clin_pkg::CHIDX_W-1:0] out_ch_r;

  logic                         accept;
  logic                         out_load;
  logic                         mem_rd_en;
  logic                         mem_wr_en;
  logic                         mul_start;
  logic                         mul_done;
  logic signed [DW-1:0]         mul_part;
  logic signed [STATE_WIDTH-1:0] rd_data;
  logic signed [DW-1:0]         diff;
  logic signed [DW-1:0]         new_sum;
  logic signed [STATE_WIDTH-1:0] new_val;
  logic signed [STATE_WIDTH-1:0] x_wide;
  logic [CH_W-1:0]              ch_sel;
  logic [CH_W-1:0]              ch_next;
  logic                         last_stage;

  always_comb begin
    ch_sel     = (int'(cur_r) >= int'(count_sat)) ? '0 : cur_r;
    ch_next    = (int'(ch_sel) + 1 >= int'(count_sat)) ? '0 : CH_W'(ch_sel + 1'b1);
    x_wide     = STATE_WIDTH'(in_if.white_sample) <<< SHIFT;
    diff       = DW'(rd_data) - DW'(prev_r);
    new_sum    = DW'(prev_r) + mul_part;
    new_val    = new_sum[STATE_WIDTH-1:0];
    last_stage = (ORD_W'(stage_cnt_r + 1'b1) == order_sat);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      clin_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          state_nxt = (order_sat == '0) ? clin_pkg::ST_DONE : clin_pkg::ST_READ;
        end
      end
      clin_pkg::ST_READ:  state_nxt = clin_pkg::ST_DIFF;
      clin_pkg::ST_DIFF:  state_nxt = clin_pkg::ST_MUL;
      clin_pkg::ST_MUL: begin
        if (mul_done) begin
          state_nxt = clin_pkg::ST_WRITE;
        end
      end
      clin_pkg::ST_WRITE: state_nxt = last_stage ? clin_pkg::ST_DONE : clin_pkg::ST_READ;
      clin_pkg::ST_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          state_nxt = clin_pkg::ST_IDLE;
        end
      end
      default: state_nxt = clin_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = 1'b0;
    mem_rd_en   = 1'b0;
    mem_wr_en   = 1'b0;
    mul_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state_r)
      clin_pkg::ST_IDLE:  in_if.ready = 1'b1;
      clin_pkg::ST_READ:  mem_rd_en   = 1'b1;
      clin_pkg::ST_DIFF:  mul_start   = 1'b1;
      clin_pkg::ST_MUL:   ;
      clin_pkg::ST_WRITE: mem_wr_en   = 1'b1;
      clin_pkg::ST_DONE:  out_load    = !out_valid_r || out_if.ready;
      default: ;
    endcase
  end

  assign accept = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clin_pkg::ST_IDLE;
      cur_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cur_r <= ch_next;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ch_r        <= ch_sel;
      prev_r      <= x_wide;
      stage_cnt_r <= '0;
      addr_r      <= AW'(int'(ch_sel) * MAX_ORDER);
    end
    if (mem_wr_en) begin
      prev_r      <= new_val;
      stage_cnt_r <= ORD_W'(stage_cnt_r + 1'b1);
      addr_r      <= AW'(addr_r + 1'b1);
    end
    if (out_load) begin
      out_noise_r <= clin_pkg::SAMPLE_W'(prev_r >>> SHIFT);
      out_ch_r    <= clin_pkg::CHIDX_W'(ch_r);
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.noise_sample  = out_noise_r;
  assign out_if.channel_index = out_ch_r;

  clin_stage_mem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (STATE_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mem_wr_en),
    .wr_addr (addr_r),
    .wr_data (new_val),
    .rd_en   (mem_rd_en),
    .rd_addr (addr_r),
    .rd_data (rd_data)
  );

  clin_digit_mul #(
    .DW (DW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .diff  (diff),
    .leak  (leak_sat),
    .done  (mul_done),
    .part  (mul_part)
  );

`ifndef SYNTHESIS
  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == clin_pkg::ST_MUL)
    else $error("multiplier finished outside the multiply state");

  a_order0_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && order_sat == '0) |=> state_r == clin_pkg::ST_DONE)
    else $error("pass-through item did not go straight to output");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_wr_en |-> stage_cnt_r < order_sat)
    else $error("stage write beyond the configured order");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == clin_pkg::ST_DONE)
    else $error("output beat raised outside the done state");
`endif

endmodule
`default_nettype wire
